// ----- sv/tcw_pkg.sv -----
// Shared types and constants for the text console writer.
// Used by tcw_front, tcw_queue, tcw_back and text_console_writer_top.
`default_nettype none

package tcw_pkg;

  // Widths fixed by the stream fields
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'd32;

  // Item kind as it arrives on tuser
  typedef enum logic [1:0] {
    KIND_PUT   = 2'd0,
    KIND_BKSP  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_READ  = 2'd3
  } kind_t;

  // Classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_PUT,
    OP_NEWLINE,
    OP_BKSP,
    OP_CLEAR,
    OP_READ,
    OP_READ_NONE
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [CHAR_W-1:0] ch;
    logic [ATTR_W-1:0] attr;
    logic [ROW_W-1:0]  rrow;
    logic [COL_W-1:0]  rcol;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BLANK,
    ST_READ
  } state_t;

endpackage

`default_nettype wire

// ----- sv/text_console_writer_top.sv -----
// Text console writer: a ROWS x COLUMNS screen of character/attribute cells in
// one on-chip memory with a cursor. Each input word is decoded by the front end
// and queued (two entries), so the input side keeps accepting, until the queue
// is full, while a result waits. The executor takes words from the queue when
// idle with no result pending and handles one word at a time: put, newline,
// backspace and out-of-range reads answer directly, an in-range read goes
// through the registered memory read first. A newline on the bottom row, or a
// put that fills the last column there, scrolls by moving a row offset and
// blanking one row through the single write port. A clear blanks every cell.
// The next word starts only after the previous result has been taken. Cell
// contents are undefined after reset until a clear has been issued.
// Depends on tcw_pkg, tcw_front, tcw_queue, tcw_back.
`default_nettype none

module text_console_writer_top #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // char_code[7:0], attribute[15:8], read_row[20:16], read_col[27:21], zero pad
  input  wire logic [31:0] s_axis_tdata,
  // kind[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // cursor_row[4:0], cursor_col[11:5], read_char[19:12], read_attr[27:20], zero pad
  output logic [31:0]      m_axis_tdata
);

  tcw_pkg::cmd_t front_cmd;
  tcw_pkg::cmd_t queue_cmd;
  logic          front_valid;
  logic          front_ready;
  logic          queue_valid;
  logic          queue_ready;

  tcw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cmd_valid     (front_valid),
    .cmd_ready     (front_ready),
    .cmd           (front_cmd)
  );

  tcw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_cmd   (front_cmd),
    .pop_valid  (queue_valid),
    .pop_ready  (queue_ready),
    .pop_cmd    (queue_cmd)
  );

  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (queue_valid),
    .cmd_ready     (queue_ready),
    .cmd           (queue_cmd),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

`default_nettype wire

// ----- sv/tcw_front.sv -----
// Front end: decodes an incoming word into a classified command.
// Depends on tcw_pkg.
`default_nettype none

module tcw_front #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,
  input  wire logic [1:0]  s_axis_tuser,
  output logic             cmd_valid,
  input  wire logic        cmd_ready,
  output tcw_pkg::cmd_t    cmd
);

  tcw_pkg::kind_t kind;
  logic           in_range;

  assign kind          = tcw_pkg::kind_t'(s_axis_tuser);
  assign cmd_valid     = s_axis_tvalid;
  assign s_axis_tready = cmd_ready;

  assign in_range = (32'(s_axis_tdata[20:16]) < ROWS) && (32'(s_axis_tdata[27:21]) < COLUMNS);

  always_comb begin
    cmd.ch   = s_axis_tdata[7:0];
    cmd.attr = s_axis_tdata[15:8];
    cmd.rrow = s_axis_tdata[20:16];
    cmd.rcol = s_axis_tdata[27:21];
    case (kind)
      tcw_pkg::KIND_PUT: begin
        cmd.op = (s_axis_tdata[7:0] == tcw_pkg::NEWLINE_CODE) ? tcw_pkg::OP_NEWLINE
                                                               : tcw_pkg::OP_PUT;
      end
      tcw_pkg::KIND_BKSP:  cmd.op = tcw_pkg::OP_BKSP;
      tcw_pkg::KIND_CLEAR: cmd.op = tcw_pkg::OP_CLEAR;
      tcw_pkg::KIND_READ: begin
        cmd.op = in_range ? tcw_pkg::OP_READ : tcw_pkg::OP_READ_NONE;
      end
      default: cmd.op = tcw_pkg::OP_READ_NONE;
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/tcw_queue.sv -----
// Two-entry command queue between the front end and the executor.
// Depends on tcw_pkg.
`default_nettype none

module tcw_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  wire tcw_pkg::cmd_t push_cmd,
  output logic               pop_valid,
  input  wire logic          pop_ready,
  output tcw_pkg::cmd_t      pop_cmd
);

  tcw_pkg::cmd_t entries [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          push;
  logic          pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_cmd    = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- sv/tcw_back.sv -----
// Executor: screen cell memory, cursor, scroll offset and sweep sequencer.
// Depends on tcw_pkg; fed by tcw_queue.
`default_nettype none

module tcw_back #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  output logic               cmd_ready,
  input  wire tcw_pkg::cmd_t cmd,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output logic [31:0]        m_axis_tdata
);

  localparam int DEPTH = ROWS * COLUMNS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS);

  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
  localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);

  // Cell memory: attribute in the high byte, character in the low byte
  logic [15:0]   mem [DEPTH];
  logic          we;
  logic [AW-1:0] waddr;
  logic [15:0]   wdata;
  logic          re;
  logic [AW-1:0] raddr;
  logic [15:0]   rdata;

  tcw_pkg::state_t state, state_next;
  logic [RW-1:0]   row, row_next;
  logic [CW-1:0]   col, col_next;
  logic [RW-1:0]   top, top_next;
  logic [AW-1:0]   sweep_addr, sweep_addr_next;
  logic [AW-1:0]   sweep_end, sweep_end_next;
  logic [7:0]      fill_attr, fill_attr_next;
  logic            out_valid, out_valid_next;
  logic [RW-1:0]   out_row, out_row_next;
  logic [CW-1:0]   out_col, out_col_next;
  logic [7:0]      out_char, out_char_next;
  logic [7:0]      out_attr, out_attr_next;

  logic [AW-1:0]   cur_addr;
  logic [AW-1:0]   rd_addr;
  logic [AW-1:0]   top_base;
  logic [RW-1:0]   top_inc;
  logic            pop;

  // Map a screen row onto its physical row through the scroll offset
  function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] r, input logic [RW-1:0] t);
    logic [RW:0] sum;
    sum = {1'b0, r} + {1'b0, t};
    if (32'(sum) >= ROWS) begin
      sum = sum - (RW+1)'(ROWS);
    end
    return sum[RW-1:0];
  endfunction

  assign cur_addr = AW'(phys_row(row, top) * COLUMNS) + AW'(col);
  assign rd_addr  = AW'(phys_row(cmd.rrow[RW-1:0], top) * COLUMNS) + AW'(cmd.rcol[CW-1:0]);
  assign top_base = AW'(top * COLUMNS);
  assign top_inc  = (top == LAST_ROW) ? '0 : top + RW'(1);

  assign cmd_ready = (state == tcw_pkg::ST_IDLE) && !out_valid;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_comb begin
    state_next      = state;
    row_next        = row;
    col_next        = col;
    top_next        = top;
    sweep_addr_next = sweep_addr;
    sweep_end_next  = sweep_end;
    fill_attr_next  = fill_attr;
    out_valid_next  = out_valid && !m_axis_tready;
    out_row_next    = out_row;
    out_col_next    = out_col;
    out_char_next   = out_char;
    out_attr_next   = out_attr;
    we              = 1'b0;
    waddr           = cur_addr;
    wdata           = {cmd.attr, cmd.ch};
    re              = 1'b0;
    raddr           = rd_addr;

    case (state)
      tcw_pkg::ST_IDLE: begin
        if (pop) begin
          case (cmd.op)
            tcw_pkg::OP_PUT, tcw_pkg::OP_NEWLINE: begin
              we = (cmd.op == tcw_pkg::OP_PUT);
              if ((cmd.op == tcw_pkg::OP_NEWLINE) || (col == LAST_COL)) begin
                col_next = '0;
                if (row != LAST_ROW) begin
                  row_next       = row + RW'(1);
                  out_valid_next = 1'b1;
                  out_row_next   = row + RW'(1);
                  out_col_next   = '0;
                  out_char_next  = '0;
                  out_attr_next  = '0;
                end else begin
                  // scroll: advance the top row, blank the old top as new bottom
                  top_next        = top_inc;
                  sweep_addr_next = top_base;
                  sweep_end_next  = top_base + AW'(COLUMNS - 1);
                  fill_attr_next  = cmd.attr;
                  state_next      = tcw_pkg::ST_BLANK;
                end
              end else begin
                col_next       = col + CW'(1);
                out_valid_next = 1'b1;
                out_row_next   = row;
                out_col_next   = col + CW'(1);
                out_char_next  = '0;
                out_attr_next  = '0;
              end
            end
            tcw_pkg::OP_BKSP: begin
              we             = 1'b1;
              wdata          = {cmd.attr, tcw_pkg::BLANK_CODE};
              waddr          = (col != '0) ? cur_addr - AW'(1) : cur_addr;
              col_next       = (col != '0) ? col - CW'(1) : col;
              out_valid_next = 1'b1;
              out_row_next   = row;
              out_col_next   = (col != '0) ? col - CW'(1) : col;
              out_char_next  = '0;
              out_attr_next  = '0;
            end
            tcw_pkg::OP_CLEAR: begin
              row_next        = '0;
              col_next        = '0;
              top_next        = '0;
              sweep_addr_next = '0;
              sweep_end_next  = LAST_ADDR;
              fill_attr_next  = cmd.attr;
              state_next      = tcw_pkg::ST_BLANK;
            end
            tcw_pkg::OP_READ: begin
              re         = 1'b1;
              state_next = tcw_pkg::ST_READ;
            end
            default: begin
              out_valid_next = 1'b1;
              out_row_next   = row;
              out_col_next   = col;
              out_char_next  = '0;
              out_attr_next  = '0;
            end
          endcase
        end
      end
      tcw_pkg::ST_BLANK: begin
        we              = 1'b1;
        waddr           = sweep_addr;
        wdata           = {fill_attr, tcw_pkg::BLANK_CODE};
        sweep_addr_next = sweep_addr + AW'(1);
        if (sweep_addr == sweep_end) begin
          state_next     = tcw_pkg::ST_IDLE;
          out_valid_next = 1'b1;
          out_row_next   = row;
          out_col_next   = col;
          out_char_next  = '0;
          out_attr_next  = '0;
        end
      end
      tcw_pkg::ST_READ: begin
        state_next     = tcw_pkg::ST_IDLE;
        out_valid_next = 1'b1;
        out_row_next   = row;
        out_col_next   = col;
        out_char_next  = rdata[7:0];
        out_attr_next  = rdata[15:8];
      end
      default: state_next = tcw_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tcw_pkg::ST_IDLE;
      row       <= '0;
      col       <= '0;
      top       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      row       <= row_next;
      col       <= col_next;
      top       <= top_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    sweep_addr <= sweep_addr_next;
    sweep_end  <= sweep_end_next;
    fill_attr  <= fill_attr_next;
    out_row    <= out_row_next;
    out_col    <= out_col_next;
    out_char   <= out_char_next;
    out_attr   <= out_attr_next;
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0, out_attr, out_char,
                          tcw_pkg::COL_W'(out_col), tcw_pkg::ROW_W'(out_row)};

  a_cursor_in_range: assert property (@(posedge clk) disable iff (rst)
    (32'(col) < COLUMNS) && (32'(row) < ROWS) && (32'(top) < ROWS))
    else $error("cursor or scroll offset out of range");

  a_pop_with_free_output: assert property (@(posedge clk) disable iff (rst)
    pop |-> !out_valid)
    else $error("command taken while a result is pending");

  a_sweep_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == tcw_pkg::ST_BLANK) |-> (sweep_addr <= sweep_end))
    else $error("blank sweep ran past its end");

  a_read_follows_issue: assert property (@(posedge clk) disable iff (rst)
    (state == tcw_pkg::ST_READ) |-> $past(re))
    else $error("read result without a read issue");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_axis_tready) |=> (out_valid && $stable(m_axis_tdata)))
    else $error("pending result changed");

endmodule

`default_nettype wire
